// File: hw/rtl/qvr_pkg.sv
// qvr_pkg: shared constants for the quaternion vector rotation pipeline
// no dependencies; imported by every qvr module and the top level
`default_nettype none

package qvr_pkg;

    // default component widths of the quaternion and the vector
    localparam int QUAT_WIDTH_DEF = 16;
    localparam int VEC_WIDTH_DEF  = 16;

    // positions of the twelve products in a product bank, named row by column
    typedef enum logic [3:0] {
        PR_WX, PR_WY, PR_WZ,
        PR_XX, PR_XY, PR_XZ,
        PR_YX, PR_YY, PR_YZ,
        PR_ZX, PR_ZY, PR_ZZ
    } prod_idx_t;

    localparam int NUM_PROD = 12;

endpackage

`default_nettype wire

// File: hw/rtl/quaternion_vector_rotate.sv
// quaternion_vector_rotate: vector part of q * (p,0) * conj(q), fixed point
// one transaction per cycle while out_ready stays high; back-pressure can stall it
// five stages: q*p products, sums, t*conj(q) products, sums, round and saturate
// each stage holds a transaction until its successor is free, so bubbles close up
// rst_n (async, active low) empties the pipeline; no other state is kept
// depends on qvr_pkg, qvr_left_product, qvr_right_product, qvr_round_sat
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_x,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_y,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VEC_WIDTH-1:0]        rot_x,
    output logic signed [VEC_WIDTH-1:0]        rot_y,
    output logic signed [VEC_WIDTH-1:0]        rot_z,
    output logic                               clipped
);

    localparam int TW = QUAT_WIDTH + VEC_WIDTH + 2;
    localparam int RW = TW + QUAT_WIDTH + 2;

    logic                         t_valid;
    logic                         t_ready;
    logic signed [TW-1:0]         t_x;
    logic signed [TW-1:0]         t_y;
    logic signed [TW-1:0]         t_z;
    logic signed [TW-1:0]         t_w;
    logic signed [QUAT_WIDTH-1:0] q_x;
    logic signed [QUAT_WIDTH-1:0] q_y;
    logic signed [QUAT_WIDTH-1:0] q_z;
    logic signed [QUAT_WIDTH-1:0] q_w;
    logic                         r_valid;
    logic                         r_ready;
    logic signed [RW-1:0]         r_x;
    logic signed [RW-1:0]         r_y;
    logic signed [RW-1:0]         r_z;

    // left product q * p
    qvr_left_product #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .t_x       (t_x),
        .t_y       (t_y),
        .t_z       (t_z),
        .t_w       (t_w),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_w       (q_w)
    );

    // right product t * conj(q)
    qvr_right_product #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .t_x       (t_x),
        .t_y       (t_y),
        .t_z       (t_z),
        .t_w       (t_w),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_w       (q_w),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .r_x       (r_x),
        .r_y       (r_y),
        .r_z       (r_z)
    );

    // rounding, saturation and output register
    qvr_round_sat #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .VEC_WIDTH  (VEC_WIDTH)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .r_x       (r_x),
        .r_y       (r_y),
        .r_z       (r_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .clipped   (clipped)
    );

endmodule

`default_nettype wire

// File: hw/rtl/qvr_left_product.sv
// qvr_left_product: t = q * (px,py,pz,0), two register stages
// stage a holds the twelve q by p products, stage b the four sums
// depends on qvr_pkg
`default_nettype none

module qvr_left_product
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    localparam int PW = QUAT_WIDTH + VEC_WIDTH,
    localparam int TW = PW + 2
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_x,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_y,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [TW-1:0]               t_x,
    output logic signed [TW-1:0]               t_y,
    output logic signed [TW-1:0]               t_z,
    output logic signed [TW-1:0]               t_w,
    output logic signed [QUAT_WIDTH-1:0]       q_x,
    output logic signed [QUAT_WIDTH-1:0]       q_y,
    output logic signed [QUAT_WIDTH-1:0]       q_z,
    output logic signed [QUAT_WIDTH-1:0]       q_w
);

    logic                         a_valid_reg;
    logic                         b_valid_reg;
    logic                         a_ready;
    logic                         b_ready;
    logic signed [PW-1:0]         prod_reg [NUM_PROD];
    logic signed [PW-1:0]         prod_next [NUM_PROD];
    logic signed [QUAT_WIDTH-1:0] qa_reg [4];
    logic signed [QUAT_WIDTH-1:0] qb_reg [4];
    logic signed [TW-1:0]         t_reg [4];
    logic signed [TW-1:0]         t_next [4];

    // ready chain: a stage takes a new transaction when empty or draining
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // products of every quaternion component with every vector component
    always_comb
    begin
        prod_next[PR_WX] = quat_w * vec_x;
        prod_next[PR_WY] = quat_w * vec_y;
        prod_next[PR_WZ] = quat_w * vec_z;
        prod_next[PR_XX] = quat_x * vec_x;
        prod_next[PR_XY] = quat_x * vec_y;
        prod_next[PR_XZ] = quat_x * vec_z;
        prod_next[PR_YX] = quat_y * vec_x;
        prod_next[PR_YY] = quat_y * vec_y;
        prod_next[PR_YZ] = quat_y * vec_z;
        prod_next[PR_ZX] = quat_z * vec_x;
        prod_next[PR_ZY] = quat_z * vec_y;
        prod_next[PR_ZZ] = quat_z * vec_z;
    end

    // hamilton product with a pure quaternion
    always_comb
    begin
        t_next[0] = TW'(prod_reg[PR_WX]) + TW'(prod_reg[PR_YZ]) - TW'(prod_reg[PR_ZY]);
        t_next[1] = TW'(prod_reg[PR_WY]) + TW'(prod_reg[PR_ZX]) - TW'(prod_reg[PR_XZ]);
        t_next[2] = TW'(prod_reg[PR_WZ]) + TW'(prod_reg[PR_XY]) - TW'(prod_reg[PR_YX]);
        t_next[3] = -TW'(prod_reg[PR_XX]) - TW'(prod_reg[PR_YY]) - TW'(prod_reg[PR_ZZ]);
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            prod_reg  <= prod_next;
            qa_reg[0] <= quat_x;
            qa_reg[1] <= quat_y;
            qa_reg[2] <= quat_z;
            qa_reg[3] <= quat_w;
        end
        if (b_ready)
        begin
            t_reg  <= t_next;
            qb_reg <= qa_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign t_x = t_reg[0];
    assign t_y = t_reg[1];
    assign t_z = t_reg[2];
    assign t_w = t_reg[3];
    assign q_x = qb_reg[0];
    assign q_y = qb_reg[1];
    assign q_z = qb_reg[2];
    assign q_w = qb_reg[3];

endmodule

`default_nettype wire

// File: hw/rtl/qvr_right_product.sv
// qvr_right_product: vector part of t * conj(q), two register stages
// stage a holds the twelve t by q products, stage b the three sums
// depends on qvr_pkg
`default_nettype none

module qvr_right_product
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    localparam int TW  = QUAT_WIDTH + VEC_WIDTH + 2,
    localparam int RPW = TW + QUAT_WIDTH,
    localparam int RW  = RPW + 2
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [TW-1:0]          t_x,
    input  wire logic signed [TW-1:0]          t_y,
    input  wire logic signed [TW-1:0]          t_z,
    input  wire logic signed [TW-1:0]          t_w,
    input  wire logic signed [QUAT_WIDTH-1:0]  q_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  q_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  q_z,
    input  wire logic signed [QUAT_WIDTH-1:0]  q_w,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [RW-1:0]               r_x,
    output logic signed [RW-1:0]               r_y,
    output logic signed [RW-1:0]               r_z
);

    // product bank naming: first letter is the t component, second the q one (q_w on the diagonal)
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic                 a_ready;
    logic                 b_ready;
    logic signed [RPW-1:0] prod_reg [NUM_PROD];
    logic signed [RPW-1:0] prod_next [NUM_PROD];
    logic signed [RW-1:0]  r_reg [3];
    logic signed [RW-1:0]  r_next [3];

    // ready chain
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // products: index row is the t component, column the q component, q_w on the diagonal
    always_comb
    begin
        prod_next[PR_WX] = t_w * q_x;
        prod_next[PR_WY] = t_w * q_y;
        prod_next[PR_WZ] = t_w * q_z;
        prod_next[PR_XX] = t_x * q_w;
        prod_next[PR_XY] = t_x * q_y;
        prod_next[PR_XZ] = t_x * q_z;
        prod_next[PR_YX] = t_y * q_x;
        prod_next[PR_YY] = t_y * q_w;
        prod_next[PR_YZ] = t_y * q_z;
        prod_next[PR_ZX] = t_z * q_x;
        prod_next[PR_ZY] = t_z * q_y;
        prod_next[PR_ZZ] = t_z * q_w;
    end

    // multiply by the conjugate, vector part only
    // (the diagonal slots of x, y and z hold the products with q_w)
    always_comb
    begin
        r_next[0] = RW'(prod_reg[PR_XX]) - RW'(prod_reg[PR_WX])
                  - RW'(prod_reg[PR_YZ]) + RW'(prod_reg[PR_ZY]);
        r_next[1] = RW'(prod_reg[PR_YY]) - RW'(prod_reg[PR_WY])
                  - RW'(prod_reg[PR_ZX]) + RW'(prod_reg[PR_XZ]);
        r_next[2] = RW'(prod_reg[PR_ZZ]) - RW'(prod_reg[PR_WZ])
                  - RW'(prod_reg[PR_XY]) + RW'(prod_reg[PR_YX]);
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            prod_reg <= prod_next;
        end
        if (b_ready)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign r_x = r_reg[0];
    assign r_y = r_reg[1];
    assign r_z = r_reg[2];

endmodule

`default_nettype wire

// File: hw/rtl/qvr_round_sat.sv
// qvr_round_sat: round to nearest, saturate to the vector width, output register
// depends on qvr_pkg
`default_nettype none

module qvr_round_sat
    import qvr_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
    localparam int RW   = 2 * QUAT_WIDTH + VEC_WIDTH + 4,
    localparam int FRAC = 2 * (QUAT_WIDTH - 2),
    localparam int SW   = RW + 1 - FRAC
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [RW-1:0]          r_x,
    input  wire logic signed [RW-1:0]          r_y,
    input  wire logic signed [RW-1:0]          r_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VEC_WIDTH-1:0]        rot_x,
    output logic signed [VEC_WIDTH-1:0]        rot_y,
    output logic signed [VEC_WIDTH-1:0]        rot_z,
    output logic                               clipped
);

    localparam logic signed [RW:0] HALF =
        {{(RW + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

    logic                        valid_reg;
    logic                        stage_ready;
    logic signed [VEC_WIDTH-1:0] rot_reg [3];
    logic signed [VEC_WIDTH-1:0] rot_next [3];
    logic                        clip_reg;
    logic                        clip_next;
    logic [2:0]                  clip_each;

    // round half up by floor((v + half) / 2^frac), then clamp
    function automatic logic [VEC_WIDTH:0] round_sat(input logic signed [RW-1:0] v);
        logic signed [RW:0]   biased;
        logic signed [SW-1:0] shifted;
        logic [VEC_WIDTH:0]   res;
        biased  = (RW + 1)'(v) + HALF;
        shifted = SW'(biased >>> FRAC);
        if (shifted > SAT_HI)
        begin
            res = {1'b1, SAT_HI[VEC_WIDTH-1:0]};
        end
        else if (shifted < SAT_LO)
        begin
            res = {1'b1, SAT_LO[VEC_WIDTH-1:0]};
        end
        else
        begin
            res = {1'b0, shifted[VEC_WIDTH-1:0]};
        end
        return res;
    endfunction

    assign stage_ready = !valid_reg || out_ready;
    assign in_ready    = stage_ready;

    // per-component rounding and clamp
    always_comb
    begin
        {clip_each[0], rot_next[0]} = round_sat(r_x);
        {clip_each[1], rot_next[1]} = round_sat(r_y);
        {clip_each[2], rot_next[2]} = round_sat(r_z);
        clip_next = |clip_each;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (stage_ready)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];
    assign clipped   = clip_reg;

endmodule

`default_nettype wire

// File: tb/sv/quaternion_vector_rotate_test.sv
// quaternion_vector_rotate_test: self-checking testbench of quaternion_vector_rotate
// a directed table, then random transactions; typed rows are checked against their row,
// the rest against a local fixed-point model of q * (p,0) * conj(q); depends on qvr_pkg and the rtl top level
`timescale 1ns / 100ps

module quaternion_vector_rotate_test
    import qvr_pkg::*;
();

    localparam int QW          = QUAT_WIDTH_DEF;
    localparam int VW          = VEC_WIDTH_DEF;
    localparam int FRAC_BITS   = 2 * (QW - 2);
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_MAX  = 10;

    // one input transaction and one rotated result
    typedef struct {
        logic signed [QW-1:0] qx, qy, qz, qw;
        logic signed [VW-1:0] px, py, pz;
    } rot_in_t;

    typedef struct {
        logic signed [VW-1:0] rx, ry, rz;
        logic                 clip;
    } rot_out_t;

    // directed row: quaternion, vector, whether the result is typed in, the result
    typedef struct packed {
        logic [15:0] qx, qy, qz, qw;
        logic [15:0] px, py, pz;
        logic        typed;
        logic [15:0] rx, ry, rz;
        logic        clip;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // all zero
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // identity passes the vector through, extremes included
        '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h7fff, 16'h8000, 16'h1234,
          1'b1, 16'h7fff, 16'h8000, 16'h1234, 1'b0},
        // zero quaternion collapses any vector
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff,
          1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // w = -2.0 scales by four, saturating both ways
        '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h1000, 16'h8000,
          1'b1, 16'h7fff, 16'h4000, 16'h8000, 1'b1},
        // half turn about z, negating the most negative x clips
        '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h0064, 16'hfffb,
          1'b1, 16'h7fff, 16'hff9c, 16'hfffb, 1'b1},
        // half turn about x
        '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'hfd00,
          1'b1, 16'h0100, 16'hfe00, 16'h0300, 1'b0},
        // half turn about y
        '{16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
          1'b1, 16'hffff, 16'h0002, 16'hfffd, 1'b0},
        // quarter scale, ties round toward plus infinity
        '{16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h0002, 16'hfffe, 16'h0003,
          1'b1, 16'h0001, 16'h0000, 16'h0001, 1'b0},
        // quarter scale, non-tie rounding
        '{16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h0001, 16'hffff, 16'hfffd,
          1'b1, 16'h0000, 16'h0000, 16'hffff, 1'b0},
        // w = -1.0 rotates like the identity
        '{16'h0000, 16'h0000, 16'h0000, 16'hc000, 16'hffff, 16'h0000, 16'h0001,
          1'b1, 16'hffff, 16'h0000, 16'h0001, 1'b0},
        // full-scale positive everywhere
        '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // most negative codes everywhere, then with a full-scale positive vector
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // quarter turn about z, inexact unit quaternion; then mixed extreme codes
        '{16'h0000, 16'h0000, 16'h2d41, 16'h2d41, 16'h0100, 16'h0000, 16'h0000,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // tiny quaternions, then w just below 2.0
        '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h8000, 16'h8000, 16'h8000,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0100, 16'hff00, 16'h0080,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // non-unit quaternion scales by its squared norm
        '{16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0100, 16'h0200, 16'h0300,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        // third of a turn about the diagonal
        '{16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h0100, 16'h0000, 16'h0000,
          1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [QW-1:0] quat_x = '0;
    logic signed [QW-1:0] quat_y = '0;
    logic signed [QW-1:0] quat_z = '0;
    logic signed [QW-1:0] quat_w = '0;
    logic signed [VW-1:0] vec_x = '0;
    logic signed [VW-1:0] vec_y = '0;
    logic signed [VW-1:0] vec_z = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic                 clipped;

    // typed-in result that travels with the current input transaction
    logic     typed_row = 1'b0;
    rot_out_t typed_want = '{rx: '0, ry: '0, rz: '0, clip: 1'b0};

    rot_out_t pending_rotations [$];
    int       mismatch_count = 0;
    int       error_count = 0;
    int       send_burst = 0;
    bit       random_phase = 1'b0;

    quaternion_vector_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .clipped   (clipped)
    );

    always #1 clk = ~clk;

    // round half up by the fraction bits, then clamp to the vector width
    function automatic logic signed [VW-1:0] round_clamp(input longint v, inout logic clip);
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (VW - 1)) - 1;
        lo = -hi - 1;
        r = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > hi)
        begin
            r = hi;
            clip = 1'b1;
        end
        if (r < lo)
        begin
            r = lo;
            clip = 1'b1;
        end
        return r[VW-1:0];
    endfunction

    // exact sandwich product q * (p,0) * conj(q), vector part only
    function automatic rot_out_t sandwich_rotate(input rot_in_t a);
        longint x, y, z, w, px, py, pz;
        longint tx, ty, tz, tw, ux, uy, uz;
        rot_out_t res;
        x  = a.qx;
        y  = a.qy;
        z  = a.qz;
        w  = a.qw;
        px = a.px;
        py = a.py;
        pz = a.pz;
        tx = w * px + y * pz - z * py;
        ty = w * py + z * px - x * pz;
        tz = w * pz + x * py - y * px;
        tw = -(x * px) - y * py - z * pz;
        ux = tx * w - tw * x - ty * z + tz * y;
        uy = ty * w - tw * y - tz * x + tx * z;
        uz = tz * w - tw * z - tx * y + ty * x;
        res.clip = 1'b0;
        res.rx = round_clamp(ux, res.clip);
        res.ry = round_clamp(uy, res.clip);
        res.rz = round_clamp(uz, res.clip);
        return res;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] corner_code();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'h0001;
            4:       return 16'hffff;
            5:       return 16'h4000;
            default: return 16'hc000;
        endcase
    endfunction

    // random transaction from a mix of realistic and stress shapes
    function automatic rot_in_t random_item();
        rot_in_t a;
        int      mode;
        int      r;
        r = $urandom_range(0, 99);
        mode = (r < 30) ? 0 : (r < 55) ? 1 : (r < 75) ? 2 : 3;
        case (mode)
            // quaternion of norm at most one, full-range vector
            0:
            begin
                a.qx = QW'($urandom_range(0, 16384) - 8192);
                a.qy = QW'($urandom_range(0, 16384) - 8192);
                a.qz = QW'($urandom_range(0, 16384) - 8192);
                a.qw = QW'($urandom_range(0, 16384) - 8192);
                a.px = VW'($urandom);
                a.py = VW'($urandom);
                a.pz = VW'($urandom);
            end
            // anything goes
            1:
            begin
                a.qx = QW'($urandom);
                a.qy = QW'($urandom);
                a.qz = QW'($urandom);
                a.qw = QW'($urandom);
                a.px = VW'($urandom);
                a.py = VW'($urandom);
                a.pz = VW'($urandom);
            end
            // corner codes per component
            2:
            begin
                a.qx = corner_code();
                a.qy = corner_code();
                a.qz = corner_code();
                a.qw = corner_code();
                a.px = corner_code();
                a.py = corner_code();
                a.pz = corner_code();
            end
            // modest rotation of a short vector
            default:
            begin
                a.qx = QW'($urandom_range(0, 16384) - 8192);
                a.qy = QW'($urandom_range(0, 16384) - 8192);
                a.qz = QW'($urandom_range(0, 16384) - 8192);
                a.qw = QW'($urandom_range(0, 16384) - 8192);
                a.px = VW'($urandom_range(0, 4096) - 2048);
                a.py = VW'($urandom_range(0, 4096) - 2048);
                a.pz = VW'($urandom_range(0, 4096) - 2048);
            end
        endcase
        return a;
    endfunction

    // offer one transaction after an optional gap and wait for its acceptance
    task automatic send_item(input rot_in_t a, input logic typed, input rot_out_t want);
        int gap;
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(10, 40);
            gap = idle_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        quat_x     <= a.qx;
        quat_y     <= a.qy;
        quat_z     <= a.qz;
        quat_w     <= a.qw;
        vec_x      <= a.px;
        vec_y      <= a.py;
        vec_z      <= a.pz;
        typed_row  <= typed;
        typed_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // reset, stimulus, drain and verdict
    initial
    begin
        rot_in_t  a;
        rot_out_t want;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            a.qx = DIR_TAB[i].qx;
            a.qy = DIR_TAB[i].qy;
            a.qz = DIR_TAB[i].qz;
            a.qw = DIR_TAB[i].qw;
            a.px = DIR_TAB[i].px;
            a.py = DIR_TAB[i].py;
            a.pz = DIR_TAB[i].pz;
            want.rx = DIR_TAB[i].rx;
            want.ry = DIR_TAB[i].ry;
            want.rz = DIR_TAB[i].rz;
            want.clip = DIR_TAB[i].clip;
            send_item(a, DIR_TAB[i].typed, want);
        end

        // random part
        random_phase = 1'b1;
        want = '{rx: '0, ry: '0, rz: '0, clip: 1'b0};
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_item(random_item(), 1'b0, want);

        // drain
        in_valid <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // receiver: random ready pattern with one long hold-off during the random part
    initial
    begin
        int  run;
        int  gap;
        bit  hold_done;
        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            if (random_phase && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = idle_len();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // record expectations on input transactions, check output transactions
    always @(posedge clk)
    begin : track_results
        rot_in_t  cur;
        rot_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                cur.qx = quat_x;
                cur.qy = quat_y;
                cur.qz = quat_z;
                cur.qw = quat_w;
                cur.px = vec_x;
                cur.py = vec_y;
                cur.pz = vec_z;
                if (typed_row)
                    pending_rotations.push_back(typed_want);
                else
                    pending_rotations.push_back(sandwich_rotate(cur));
            end
            if (out_valid && out_ready)
            begin
                if (pending_rotations.size() == 0)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result x=%0d y=%0d z=%0d clip=%0b",
                                 rot_x, rot_y, rot_z, clipped);
                end
                else
                begin
                    want = pending_rotations.pop_front();
                    if (rot_x !== want.rx || rot_y !== want.ry || rot_z !== want.rz ||
                        clipped !== want.clip)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: want %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                     want.rx, want.ry, want.rz, want.clip,
                                     rot_x, rot_y, rot_z, clipped);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
